/* hw/rtl/line_edit_buffer_unit_macros.svh */
// Assertion macros for the line edit buffer RTL.
// Used by line_edit_buffer_unit.sv; bodies drop out when SYNTHESIS is defined.
`ifndef LINE_EDIT_BUFFER_UNIT_MACROS_SVH
`define LINE_EDIT_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LEB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_edit_buffer: check failed");

// Next-cycle implication, checked outside reset.
`define LEB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_edit_buffer: check failed");

`else

`define LEB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LEB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/leb_pkg.sv */
// Shared types and constants for the line edit buffer.
// No dependencies; used by line_edit_buffer_unit.sv.
`timescale 1ns / 1ps

package leb_pkg;

    // Text store geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 6;   // cursor / length / max_length fields

    localparam logic [CNT_W-1:0] MAX_LEN_RESET = 6'd20;

    // Printable range
    localparam logic [7:0] CHAR_MIN = 8'd32;
    localparam logic [7:0] CHAR_MAX = 8'd127;

    // Register byte-address bit that selects the register index
    localparam logic REG_MAX_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        KIND_CHAR  = 3'd0,
        KIND_LEFT  = 3'd1,
        KIND_RIGHT = 3'd2,
        KIND_HOME  = 3'd3,
        KIND_END   = 3'd4,
        KIND_BACK  = 3'd5,
        KIND_DEL   = 3'd6,
        KIND_READ  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_IGNORED  = 2'd1,
        STAT_PAST_END = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/line_edit_buffer_unit.sv */
// Line edit buffer: one-line text store with a cursor, driven by key events.
// Depends on leb_pkg.sv and line_edit_buffer_unit_macros.svh.
//
// Usage:
//   Input channel  (i_in_valid / o_in_stall): one key event per transfer,
//     fields i_kind, i_char_code, i_read_index.
//   Output channel (o_out_valid / i_out_stall): one result per event,
//     fields o_cursor_pos, o_text_length, o_read_char, o_status.
//   APB port: register 0 (byte address 0) is max_length, 6 bits, reset 20.
//     Write it only while no event is in flight.
// Sequence per event: a read inside the text passes through ST_EXEC,
//   ST_READ_WAIT and ST_DONE; a backspace or delete that removes a character
//   walks the tail in ST_SHIFT_RD and ST_SHIFT_WR, one pair per character
//   moved (at most 31), before ST_DONE; any other event goes from ST_EXEC
//   straight to ST_DONE. No new event is taken while one is in flight; the
//   next is taken once the result has been loaded.
// Reset clears cursor and length and restores max_length; the text store is
//   not cleared, entries at or beyond the length are never returned.
// A stalled result stays in the output register; the block still takes and
//   works on the next event, then holds it in ST_DONE until the output frees.
`timescale 1ns / 1ps
`include "line_edit_buffer_unit_macros.svh"

module line_edit_buffer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_read_index,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_cursor_pos,
    output logic [5:0]  o_text_length,
    output logic [6:0]  o_read_char,
    output logic [1:0]  o_status,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = leb_pkg::IDX_W;
    localparam int CW = leb_pkg::CNT_W;

    // Sequencer and architectural state
    leb_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_length, n_length;
    logic [CW-1:0]    r_max_length;

    // Latched event
    leb_pkg::t_kind   r_kind;
    logic [7:0]       r_code;
    logic [4:0]       r_ridx;

    // Shift walker: source index and end bound (old length)
    logic [CW-1:0]    r_src, n_src;
    logic [CW-1:0]    r_limit, n_limit;

    // Working result
    leb_pkg::t_status r_status, n_status;
    logic [6:0]       r_rchar, n_rchar;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_out_cursor;
    logic [CW-1:0]    r_out_length;
    logic [6:0]       r_out_char;
    leb_pkg::t_status r_out_status;

    // Text store
    logic [6:0]       r_mem [leb_pkg::CAPACITY];
    logic [6:0]       r_rdata;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [6:0]       mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;

    logic             in_xfer;
    logic             out_free;
    logic             cfg_wr;
    logic [CW-1:0]    eff_max;
    logic [CW-1:0]    src_m1;
    logic             printable;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Effective maximum: clamp the register to the store capacity
    assign eff_max = (r_max_length > CW'(leb_pkg::CAPACITY)) ?
                     CW'(leb_pkg::CAPACITY) : r_max_length;

    assign printable = (r_code >= leb_pkg::CHAR_MIN) && (r_code <= leb_pkg::CHAR_MAX);
    assign src_m1    = r_src - CW'(1);

    assign o_in_stall    = (r_state != leb_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cursor_pos  = r_out_cursor;
    assign o_text_length = r_out_length;
    assign o_read_char   = r_out_char;
    assign o_status      = r_out_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == leb_pkg::REG_MAX_LENGTH) ?
                    {{(32-CW){1'b0}}, r_max_length} : 32'd0;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            leb_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = leb_pkg::ST_EXEC;
                end
            end
            leb_pkg::ST_EXEC: begin
                case (r_kind)
                    leb_pkg::KIND_BACK: begin
                        n_state = (r_cursor == '0) ? leb_pkg::ST_DONE
                                                   : leb_pkg::ST_SHIFT_RD;
                    end
                    leb_pkg::KIND_DEL: begin
                        n_state = (r_cursor < r_length) ? leb_pkg::ST_SHIFT_RD
                                                        : leb_pkg::ST_DONE;
                    end
                    leb_pkg::KIND_READ: begin
                        n_state = (CW'(r_ridx) < r_length) ? leb_pkg::ST_READ_WAIT
                                                           : leb_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = leb_pkg::ST_DONE;
                    end
                endcase
            end
            leb_pkg::ST_SHIFT_RD: begin
                n_state = (r_src < r_limit) ? leb_pkg::ST_SHIFT_WR : leb_pkg::ST_DONE;
            end
            leb_pkg::ST_SHIFT_WR: begin
                n_state = leb_pkg::ST_SHIFT_RD;
            end
            leb_pkg::ST_READ_WAIT: begin
                n_state = leb_pkg::ST_DONE;
            end
            leb_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = leb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = leb_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and store control
    // ------------------------------------------------------------------
    always_comb begin
        n_cursor    = r_cursor;
        n_length    = r_length;
        n_src       = r_src;
        n_limit     = r_limit;
        n_status    = r_status;
        n_rchar     = r_rchar;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_cursor[IW-1:0];
        mem_wdata   = r_code[6:0];
        mem_re      = 1'b0;
        mem_raddr   = r_src[IW-1:0];

        // Drop the result once the receiver takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            leb_pkg::ST_EXEC: begin
                n_status = leb_pkg::STAT_OK;
                n_rchar  = '0;
                case (r_kind)
                    leb_pkg::KIND_CHAR: begin
                        if (!printable || (r_cursor >= eff_max)) begin
                            n_status = leb_pkg::STAT_IGNORED;
                        end else begin
                            // Overwrite at the cursor, advance, grow if passed
                            mem_we   = 1'b1;
                            n_cursor = r_cursor + CW'(1);
                            if (r_cursor >= r_length) begin
                                n_length = r_cursor + CW'(1);
                            end
                        end
                    end
                    leb_pkg::KIND_LEFT: begin
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - CW'(1);
                        end else begin
                            n_status = leb_pkg::STAT_IGNORED;
                        end
                    end
                    leb_pkg::KIND_RIGHT: begin
                        if (r_cursor < r_length) begin
                            n_cursor = r_cursor + CW'(1);
                        end else begin
                            n_status = leb_pkg::STAT_IGNORED;
                        end
                    end
                    leb_pkg::KIND_HOME: begin
                        n_cursor = '0;
                    end
                    leb_pkg::KIND_END: begin
                        n_cursor = r_length;
                    end
                    leb_pkg::KIND_BACK: begin
                        if (r_cursor == '0) begin
                            n_status = leb_pkg::STAT_IGNORED;
                        end else begin
                            // Move entries [cursor, length) down by one
                            n_src    = r_cursor;
                            n_limit  = r_length;
                            n_cursor = r_cursor - CW'(1);
                            n_length = r_length - CW'(1);
                        end
                    end
                    leb_pkg::KIND_DEL: begin
                        if (r_cursor < r_length) begin
                            // Move entries [cursor+1, length) down by one
                            n_src    = r_cursor + CW'(1);
                            n_limit  = r_length;
                            n_length = r_length - CW'(1);
                        end else begin
                            n_status = leb_pkg::STAT_IGNORED;
                        end
                    end
                    leb_pkg::KIND_READ: begin
                        if ((CW'(r_ridx) < r_length) &&
                            (CW'(r_ridx) < CW'(leb_pkg::CAPACITY))) begin
                            mem_re    = 1'b1;
                            mem_raddr = r_ridx[IW-1:0];
                        end else begin
                            n_status = leb_pkg::STAT_PAST_END;
                        end
                    end
                    default: begin
                        n_status = leb_pkg::STAT_OK;
                    end
                endcase
            end
            leb_pkg::ST_SHIFT_RD: begin
                if (r_src < r_limit) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_src[IW-1:0];
                end
            end
            leb_pkg::ST_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = src_m1[IW-1:0];
                mem_wdata = r_rdata;
                n_src     = r_src + CW'(1);
            end
            leb_pkg::ST_READ_WAIT: begin
                n_rchar = r_rdata;
            end
            leb_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_src = r_src;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= leb_pkg::ST_IDLE;
            r_cursor     <= '0;
            r_length     <= '0;
            r_max_length <= leb_pkg::MAX_LEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
            if (cfg_wr && (paddr[2] == leb_pkg::REG_MAX_LENGTH)) begin
                r_max_length <= pwdata[CW-1:0];
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= leb_pkg::t_kind'(i_kind);
            r_code <= i_char_code;
            r_ridx <= i_read_index;
        end
        r_src    <= n_src;
        r_limit  <= n_limit;
        r_status <= n_status;
        r_rchar  <= n_rchar;
        // Load the result only when the output register frees up
        if ((r_state == leb_pkg::ST_DONE) && out_free) begin
            r_out_cursor <= r_cursor;
            r_out_length <= r_length;
            r_out_char   <= r_rchar;
            r_out_status <= r_status;
        end
    end

    // Text store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LEB_ASSERT_IMP(a_cursor_in_text, i_clk, i_rst_n, 1'b1, r_cursor <= r_length)
    `LEB_ASSERT_IMP(a_length_in_cap, i_clk, i_rst_n, 1'b1,
                    r_length <= CW'(leb_pkg::CAPACITY))
    `LEB_ASSERT_IMP(a_shift_wr_range, i_clk, i_rst_n, r_state == leb_pkg::ST_SHIFT_WR,
                    (r_src < r_limit) && (r_src != '0))
    `LEB_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, in_xfer, r_state == leb_pkg::ST_EXEC)

endmodule

/* sim/line_edit_buffer_unit_tb.sv */
// Self-checking testbench for line_edit_buffer_unit: key events in, one result per event out.
// Depends on leb_pkg.sv and the line_edit_buffer_unit RTL; reads no files.
`timescale 1ns / 1ps

module line_edit_buffer_unit_tb;

    // The slowest event is a full tail shift; allow a generous margin on top of idling.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [2:0] ADDR_MAX_LENGTH = 3'd0;   // register 0 at byte address 0

    typedef struct packed {
        logic [5:0]       cursor_pos;
        logic [5:0]       text_length;
        logic [6:0]       read_char;
        leb_pkg::t_status status;
    } key_result_t;

    // Line state tracker: applies each accepted key event to its own copy of the
    // line and queues the result the block must return for it.
    class edit_line_scoreboard;
        logic [6:0]  line_text [leb_pkg::CAPACITY];
        logic [5:0]  cursor_q;
        logic [5:0]  length_q;
        logic [5:0]  max_len_q;
        key_result_t pending_results [$];
        int          mismatches;

        function new();
            foreach (line_text[i]) line_text[i] = '0;
            cursor_q   = '0;
            length_q   = '0;
            max_len_q  = leb_pkg::MAX_LEN_RESET;
            mismatches = 0;
        endfunction

        function void set_max_length(logic [5:0] value);
            max_len_q = value;
        endfunction

        function void note_event(leb_pkg::t_kind kind, logic [7:0] code, logic [4:0] ridx);
            key_result_t r;
            int          lim;
            r.status    = leb_pkg::STAT_OK;
            r.read_char = '0;
            // clamp the limit to the store size
            lim = (int'(max_len_q) > leb_pkg::CAPACITY) ? leb_pkg::CAPACITY
                                                         : int'(max_len_q);
            case (kind)
                leb_pkg::KIND_CHAR: begin
                    if (code < leb_pkg::CHAR_MIN || code > leb_pkg::CHAR_MAX ||
                        int'(cursor_q) >= lim) begin
                        r.status = leb_pkg::STAT_IGNORED;
                    end else begin
                        line_text[cursor_q[4:0]] = code[6:0];
                        cursor_q = cursor_q + 6'd1;
                        if (cursor_q > length_q) length_q = cursor_q;
                    end
                end
                leb_pkg::KIND_LEFT: begin
                    if (cursor_q > 0) cursor_q = cursor_q - 6'd1;
                    else r.status = leb_pkg::STAT_IGNORED;
                end
                leb_pkg::KIND_RIGHT: begin
                    if (cursor_q < length_q) cursor_q = cursor_q + 6'd1;
                    else r.status = leb_pkg::STAT_IGNORED;
                end
                leb_pkg::KIND_HOME: cursor_q = '0;
                leb_pkg::KIND_END:  cursor_q = length_q;
                leb_pkg::KIND_BACK: begin
                    if (cursor_q == 0) begin
                        r.status = leb_pkg::STAT_IGNORED;
                    end else begin
                        for (int i = int'(cursor_q); i < int'(length_q); i++)
                            line_text[i-1] = line_text[i];
                        cursor_q = cursor_q - 6'd1;
                        length_q = length_q - 6'd1;
                    end
                end
                leb_pkg::KIND_DEL: begin
                    if (cursor_q < length_q) begin
                        for (int i = int'(cursor_q); i + 1 < int'(length_q); i++)
                            line_text[i] = line_text[i+1];
                        length_q = length_q - 6'd1;
                    end else begin
                        r.status = leb_pkg::STAT_IGNORED;
                    end
                end
                default: begin
                    if (ridx < length_q) r.read_char = line_text[ridx];
                    else r.status = leb_pkg::STAT_PAST_END;
                end
            endcase
            r.cursor_pos  = cursor_q;
            r.text_length = length_q;
            pending_results.push_back(r);
        endfunction

        function void check_result(key_result_t got);
            key_result_t want;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] result with none pending: cur=%0d len=%0d chr=%0d st=%0d",
                             $realtime, got.cursor_pos, got.text_length, got.read_char,
                             got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_pos !== want.cursor_pos || got.text_length !== want.text_length ||
                got.read_char !== want.read_char || got.status !== want.status) begin
                if (mismatches < 10)
                    $display("[%0t] exp cur=%0d len=%0d chr=%0d st=%0d, got %0d %0d %0d %0d",
                             $realtime, want.cursor_pos, want.text_length, want.read_char,
                             want.status, got.cursor_pos, got.text_length, got.read_char,
                             got.status);
                mismatches++;
            end
        endfunction
    endclass

    // Block inputs start at known values
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [2:0]  i_kind       = '0;
    logic [7:0]  i_char_code  = '0;
    logic [4:0]  i_read_index = '0;
    logic        i_out_stall  = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [5:0]  o_cursor_pos;
    logic [5:0]  o_text_length;
    logic [6:0]  o_read_char;
    logic [1:0]  o_status;
    logic [31:0] prdata;
    logic        pready;

    edit_line_scoreboard sb;
    bit  allow_idling = 1'b1;   // cleared for back-to-back stretches and the tail of the run
    int  stall_left   = 0;
    int  cycle_count  = 0;

    line_edit_buffer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_char_code   (i_char_code),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cursor_pos  (o_cursor_pos),
        .o_text_length (o_text_length),
        .o_read_char   (o_read_char),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Result side: check each transfer against the oldest expectation, then
    // decide the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(key_result_t'{o_cursor_pos, o_text_length, o_read_char,
                                          leb_pkg::t_status'(o_status)});
        if (stall_left > 0)
            stall_left--;
        else if (allow_idling && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 16);
        i_out_stall <= (stall_left > 0);
    end

    // Watchdog: end the run if it never completes.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL line_edit_buffer_unit");
        $finish;
    end

    // Send one key event; optionally idle first, then hold the payload until
    // the transfer happens and record it in the scoreboard.
    task automatic send_key(leb_pkg::t_kind kind, logic [7:0] code, logic [4:0] ridx);
        int gap;
        gap = 0;
        if (allow_idling && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_char_code  <= code;
        i_read_index <= ridx;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(kind, code, ridx);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, register updates at the access edge.
    task automatic write_max_length(logic [5:0] value);
        drain_results();
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= {26'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_max_length(value);
    endtask

    // One random key event. char_pct sets how typing-heavy the mix is; reads
    // mostly land inside the text so real characters come back.
    task automatic send_random_key(int char_pct);
        int             roll;
        leb_pkg::t_kind kind;
        logic [7:0]     code;
        logic [4:0]     ridx;
        roll = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        ridx = 5'($urandom_range(0, 31));
        if (roll < char_pct) begin
            kind = leb_pkg::KIND_CHAR;
            code = 8'($urandom_range(leb_pkg::CHAR_MIN, leb_pkg::CHAR_MAX));
        end else if (roll < char_pct + 5) begin
            // non-printable noise, both below and above the printable range
            kind = leb_pkg::KIND_CHAR;
            code = $urandom_range(0, 1) ? 8'($urandom_range(0, leb_pkg::CHAR_MIN - 1))
                                        : 8'($urandom_range(leb_pkg::CHAR_MAX + 1, 255));
        end else begin
            kind = leb_pkg::t_kind'(3'($urandom_range(leb_pkg::KIND_LEFT,
                                                      leb_pkg::KIND_READ)));
            if (kind == leb_pkg::KIND_READ && sb.length_q > 0 && $urandom_range(0, 4) != 0)
                ridx = 5'($urandom_range(0, sb.length_q - 1));
        end
        send_key(kind, code, ridx);
    endtask

    int phase_max   [7] = '{32, 7, 63, 1, 0, 45, 20};
    int phase_items [7] = '{200, 180, 230, 150, 90, 200, 280};

    initial begin
        sb = new();
        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundaries on an empty line with the reset limit of 20.
        send_key(leb_pkg::KIND_READ,  8'd0, 5'd0);      // read past end on empty line
        send_key(leb_pkg::KIND_LEFT,  8'd0, 5'd0);      // left at column zero
        send_key(leb_pkg::KIND_BACK,  8'd0, 5'd0);      // backspace at column zero
        send_key(leb_pkg::KIND_DEL,   8'd0, 5'd0);      // delete at end of text
        send_key(leb_pkg::KIND_RIGHT, 8'd0, 5'd0);      // right at end of text
        send_key(leb_pkg::KIND_CHAR,  leb_pkg::CHAR_MIN - 8'd1, 5'd0);
        send_key(leb_pkg::KIND_CHAR,  8'd255, 5'd31);
        send_key(leb_pkg::KIND_CHAR,  leb_pkg::CHAR_MIN, 5'd0);
        send_key(leb_pkg::KIND_CHAR,  leb_pkg::CHAR_MAX, 5'd0);
        send_key(leb_pkg::KIND_CHAR,  8'd65, 5'd0);
        send_key(leb_pkg::KIND_CHAR,  8'd0, 5'd0);
        send_key(leb_pkg::KIND_HOME,  8'd0, 5'd0);
        send_key(leb_pkg::KIND_DEL,   8'd0, 5'd0);      // delete inside the text shifts the tail
        send_key(leb_pkg::KIND_END,   8'd0, 5'd0);
        send_key(leb_pkg::KIND_LEFT,  8'd0, 5'd0);
        send_key(leb_pkg::KIND_BACK,  8'd0, 5'd0);      // backspace mid-line
        send_key(leb_pkg::KIND_READ,  8'd0, 5'd0);
        send_key(leb_pkg::KIND_READ,  8'd0, 5'd31);
        send_key(leb_pkg::KIND_RIGHT, 8'd0, 5'd0);

        // Zero limit: every character is refused.
        write_max_length(6'd0);
        send_key(leb_pkg::KIND_CHAR, 8'd120, 5'd0);
        // Limit above the store size clamps to the capacity.
        write_max_length(6'd63);
        send_key(leb_pkg::KIND_HOME, 8'd0, 5'd0);
        send_key(leb_pkg::KIND_CHAR, 8'd122, 5'd0);
        // Limit lowered under the cursor: text kept, typing refused.
        send_key(leb_pkg::KIND_END, 8'd0, 5'd0);
        write_max_length(6'd1);
        send_key(leb_pkg::KIND_CHAR, 8'd66, 5'd0);

        // Random phases, each under its own limit; the last one runs with no idling.
        for (int p = 0; p < 7; p++) begin
            write_max_length(phase_max[p][5:0]);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 6) allow_idling = 1'b0;
                else if (n % 50 == 0) allow_idling = ($urandom_range(0, 2) != 0);
                send_random_key((p % 2 == 0) ? 60 : 30);
            end
        end

        // Wait out the remaining results, then let any stray result show up.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("PASS line_edit_buffer_unit");
        end else begin
            $display("FAIL line_edit_buffer_unit");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/leb_pkg.sv
hw/rtl/line_edit_buffer_unit.sv
sim/line_edit_buffer_unit_tb.sv
